FILE: hdl/dht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_pkg
// Shared constants and types for the double hashing table insert unit.
// ----------------------------------------------------------------------------
package dht_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int KEY_WIDTH_DEF  = 16;

	localparam int KEY_IN_W = 16;
	localparam int SLOT_W   = 10;
	localparam int COLL_W   = 11;
	localparam int BASE_W   = 10;
	localparam int OUT_W    = 2;

	localparam logic [BASE_W-1:0] BASE_RESET = 10'd7;

	typedef enum logic [OUT_W-1:0] {
		OUT_INSERTED = 2'd0,
		OUT_PRESENT  = 2'd1,
		OUT_FULL     = 2'd2
	} outcome_t;

endpackage

`default_nettype wire

FILE: hdl/double_hash_table_insert_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_table_insert_unit
// Open-addressing hash table insert with double hashing, one probe per cycle.
// ----------------------------------------------------------------------------
// From the start transfer to the done strobe the unit runs the bit-serial step
// remainder, reads the home slot and makes P table probes, one per cycle, where
// P is collisions plus one, or TABLE_SIZE when the table is full.
// A new insert is taken only once the unit is idle again; results cannot be stalled.
// After reset the unit clears the table with busy high.
module double_hash_table_insert_unit #(
	parameter int KEY_WIDTH  = dht_pkg::KEY_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step_base_we,
	input  wire logic [dht_pkg::BASE_W-1:0]  step_base,
	input  wire logic                        start,
	input  wire logic [dht_pkg::KEY_IN_W-1:0] key,
	output      logic                        busy,
	output      logic                        done,
	output      logic [dht_pkg::SLOT_W-1:0]  slot,
	output      logic [dht_pkg::COLL_W-1:0]  collisions,
	output      logic [dht_pkg::OUT_W-1:0]   outcome
);

	import dht_pkg::*;

	// The table size is a power of two, so the home slot and the wrap are masks.
	localparam int TABLE_SIZE = TABLE_SIZE_DEF;
	localparam int AW         = $clog2(TABLE_SIZE);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DIV   = 5'b00100,
		S_READ  = 5'b01000,
		S_PROBE = 5'b10000
	} state_t;

	state_t              state_q;
	logic [BASE_W-1:0]   base_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [BASE_W-1:0]   step_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       col_q;
	logic [AW-1:0]       clr_q;
	logic                done_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COLL_W-1:0]   coll_q;
	outcome_t            outcome_q;

	logic                 accept;
	logic [KEY_WIDTH-1:0] key_m;
	logic [BASE_W-1:0]    base_eff;
	logic                 u1_done;
	logic [BASE_W-1:0]    u1_rem;
	logic [AW-1:0]        next_pos;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [KEY_WIDTH:0]   ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [KEY_WIDTH:0]   ram_rdata;
	logic                 slot_used;
	logic                 key_match;

	assign accept   = start && (state_q == S_IDLE);
	assign key_m    = KEY_WIDTH'(key);
	assign base_eff = (base_q == '0) ? BASE_W'(1) : base_q;

	dht_mod #(
		.NUM_W(KEY_WIDTH),
		.DEN_W(BASE_W)
	) u_mod_step (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.num   (key_m),
		.den   (base_eff),
		.done  (u1_done),
		.rem   (u1_rem)
	);

	assign next_pos = pos_q + AW'(step_q);

	assign slot_used = ram_rdata[KEY_WIDTH];
	assign key_match = (ram_rdata[KEY_WIDTH-1:0] == key_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {1'b1, key_q};
		ram_raddr = pos_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_PROBE: begin
				ram_we    = !slot_used;
				ram_raddr = next_pos;
			end
			default: begin
			end
		endcase
	end

	dht_ram #(
		.WIDTH(KEY_WIDTH + 1),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			base_q  <= BASE_RESET;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (step_base_we) begin
				base_q <= step_base;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TABLE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (u1_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (!slot_used || key_match || col_q == AW'(TABLE_SIZE - 1)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_m;
			col_q <= '0;
			pos_q <= AW'(key_m);
		end
		if (u1_done) begin
			step_q <= base_eff - u1_rem;
		end
		if (state_q == S_PROBE) begin
			slot_q <= SLOT_W'(pos_q);
			priority if (!slot_used) begin
				coll_q    <= COLL_W'(col_q);
				outcome_q <= OUT_INSERTED;
			end else if (key_match) begin
				coll_q    <= COLL_W'(col_q);
				outcome_q <= OUT_PRESENT;
			end else if (col_q == AW'(TABLE_SIZE - 1)) begin
				coll_q    <= COLL_W'((AW + 1)'(TABLE_SIZE));
				outcome_q <= OUT_FULL;
			end else begin
				col_q <= col_q + AW'(1);
				pos_q <= next_pos;
			end
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign slot       = slot_q;
	assign collisions = coll_q;
	assign outcome    = outcome_q;

endmodule

`default_nettype wire

FILE: hdl/dht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module dht_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/dht_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dht_mod #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output      logic             done,
	output      logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			cnt_q <= CNT_W'(NUM_W);
		end else if (run_q) begin
			num_q <= num_q << 1;
			cnt_q <= cnt_q - CNT_W'(1);
			if (trial >= {1'b0, den_q}) begin
				rem_q <= diff[DEN_W-1:0];
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

FILE: hdl/dht_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks on the insert unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module dht_checker #(
	parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic [dht_pkg::COLL_W-1:0]  collisions,
	input wire logic [dht_pkg::OUT_W-1:0]   outcome
);

	import dht_pkg::*;

	// A transfer on the start side keeps the unit busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after an accepted start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (outcome == OUT_INSERTED || outcome == OUT_PRESENT ||
			outcome == OUT_FULL))
		else $error("undefined outcome code");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUT_FULL |-> collisions == COLL_W'(TABLE_SIZE))
		else $error("full table without a full collision count");

endmodule

bind double_hash_table_insert_unit dht_checker #(
	.TABLE_SIZE(TABLE_SIZE)
) u_dht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.collisions(collisions),
	.outcome   (outcome)
);

`default_nettype wire

FILE: bench/dht_insert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_insert_checker
// Watches the insert and result channels of the double hashing insert unit,
// keeps its own copy of the table and the step base, predicts every result
// and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module dht_insert_checker
	import dht_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step_base_we,
	input  wire logic [BASE_W-1:0]   step_base,
	input  wire logic                start,
	input  wire logic [KEY_IN_W-1:0] key,
	input  wire logic                busy,
	input  wire logic                done,
	input  wire logic [SLOT_W-1:0]   slot,
	input  wire logic [COLL_W-1:0]   collisions,
	input  wire logic [OUT_W-1:0]    outcome,
	output int                       errors,
	output int                       outstanding,
	output int                       n_inserted,
	output int                       n_present,
	output int                       n_full
);

	localparam int SLOTS = TABLE_SIZE_DEF;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [COLL_W-1:0] collisions;
		outcome_t          outcome;
	} insert_result_t;

	logic [KEY_IN_W-1:0] slot_key [SLOTS];
	bit                  slot_taken [SLOTS];
	logic [BASE_W-1:0]   base_reg;
	insert_result_t      expected_inserts [$];
	int                  err_cnt;
	int                  ins_cnt;
	int                  pres_cnt;
	int                  full_cnt;

	function automatic insert_result_t probe_insert(input logic [KEY_IN_W-1:0] k);
		int unsigned    base;
		int unsigned    stride;
		int unsigned    pos;
		int unsigned    hits;
		insert_result_t r;
		base = (base_reg == '0) ? 32'd1 : 32'(base_reg);
		stride = base - (32'(k) % base);
		pos = 32'(k) % SLOTS;
		hits = 0;
		r.slot = pos[SLOT_W-1:0];
		r.outcome = OUT_FULL;
		while (hits < SLOTS) begin
			r.slot = pos[SLOT_W-1:0];
			if (!slot_taken[pos[SLOT_W-1:0]]) begin
				slot_taken[pos[SLOT_W-1:0]] = 1'b1;
				slot_key[pos[SLOT_W-1:0]] = k;
				r.outcome = OUT_INSERTED;
				break;
			end
			if (slot_key[pos[SLOT_W-1:0]] == k) begin
				r.outcome = OUT_PRESENT;
				break;
			end
			hits++;
			pos = (pos + stride) % SLOTS;
		end
		r.collisions = hits[COLL_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		insert_result_t want;
		if (!arst_n) begin
			slot_taken = '{default: 1'b0};
			base_reg = BASE_RESET;
			expected_inserts.delete();
		end else begin
			if (done) begin
				if (expected_inserts.size() == 0) begin
					$error("Result with no insert pending: slot %0d, collisions %0d, outcome %0d",
						slot, collisions, outcome);
					err_cnt++;
				end else begin
					want = expected_inserts.pop_front();
					if (slot !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, slot);
						err_cnt++;
					end
					if (collisions !== want.collisions) begin
						$error("collisions: expected %0d, actual %0d",
							want.collisions, collisions);
						err_cnt++;
					end
					if (outcome !== want.outcome) begin
						$error("outcome: expected %0d, actual %0d", want.outcome, outcome);
						err_cnt++;
					end
					case (want.outcome)
						OUT_INSERTED: ins_cnt++;
						OUT_PRESENT:  pres_cnt++;
						default:      full_cnt++;
					endcase
				end
			end
			if (step_base_we) begin
				base_reg = step_base;
			end
			if (start && !busy) begin
				expected_inserts.push_back(probe_insert(key));
			end
		end
		errors      <= err_cnt;
		outstanding <= expected_inserts.size();
		n_inserted  <= ins_cnt;
		n_present   <= pres_cnt;
		n_full      <= full_cnt;
	end

endmodule

FILE: bench/double_hash_table_insert_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_insert_unit_tb
// Drives key inserts into the double hashing insert unit under several step
// base settings, with and without sender gaps, fills the table until inserts
// are rejected, and reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module double_hash_table_insert_unit_tb;
	import dht_pkg::*;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                step_base_we = 1'b0;
	logic [BASE_W-1:0]   step_base    = '0;
	logic                start        = 1'b0;
	logic [KEY_IN_W-1:0] key          = '0;
	logic                busy;
	logic                done;
	logic [SLOT_W-1:0]   slot;
	logic [COLL_W-1:0]   collisions;
	logic [OUT_W-1:0]    outcome;

	int errors;
	int outstanding;
	int n_inserted;
	int n_present;
	int n_full;
	int n_settings;

	logic [KEY_IN_W-1:0] issued_keys [$];

	double_hash_table_insert_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_base_we (step_base_we),
		.step_base    (step_base),
		.start        (start),
		.key          (key),
		.busy         (busy),
		.done         (done),
		.slot         (slot),
		.collisions   (collisions),
		.outcome      (outcome)
	);

	dht_insert_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_base_we (step_base_we),
		.step_base    (step_base),
		.start        (start),
		.key          (key),
		.busy         (busy),
		.done         (done),
		.slot         (slot),
		.collisions   (collisions),
		.outcome      (outcome),
		.errors       (errors),
		.outstanding  (outstanding),
		.n_inserted   (n_inserted),
		.n_present    (n_present),
		.n_full       (n_full)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(100_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	// Start stays high from one transfer to the next unless the caller pauses.
	task automatic send_key(input logic [KEY_IN_W-1:0] k);
		start <= 1'b1;
		key <= k;
		issued_keys.push_back(k);
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	task automatic set_step_base(input logic [BASE_W-1:0] v);
		start <= 1'b0;
		drain();
		step_base_we <= 1'b1;
		step_base <= v;
		@(posedge clk);
		step_base_we <= 1'b0;
		n_settings++;
	endtask

	task automatic pause(input int idle_pct);
		if ($urandom_range(0, 63) == 0) begin
			start <= 1'b0;
			drain();
		end else if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	// Fresh keys, keys sharing the home slot of an earlier key, and repeats.
	function automatic logic [KEY_IN_W-1:0] pick_key(input int fresh_pct);
		int                  r;
		logic [KEY_IN_W-1:0] known;
		logic [KEY_IN_W-1:0] v;
		r = $urandom_range(0, 99);
		v = KEY_IN_W'($urandom());
		if (issued_keys.size() == 0 || r < fresh_pct) begin
			return v;
		end
		known = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
		if (r < fresh_pct + 15) begin
			v = known + KEY_IN_W'($urandom_range(1, 63) * TABLE_SIZE_DEF);
			return v;
		end
		return known;
	endfunction

	initial begin
		logic [BASE_W-1:0] phase_base [4];
		int                phase_idle [4];
		int                full_mark;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// The reset step base is used first, then zero, the maximum and one.
		send_key(16'd0);
		send_key(16'd0);
		send_key(16'd1024);
		send_key(16'hFFFF);
		send_key(16'd1023);
		send_key(16'd1024);
		send_key(16'h8000);
		set_step_base('0);
		send_key(16'd2048);
		send_key(16'd3072);
		send_key(16'd0);
		set_step_base('1);
		send_key(16'hFFFF);
		send_key(16'hFBFF);
		send_key(16'd1023);
		set_step_base(10'd1);
		send_key(16'd4096);
		send_key(16'd4096);

		phase_base[0] = BASE_W'($urandom_range(3, 1022));
		phase_base[1] = 10'd1023;
		phase_base[2] = 10'd2;
		phase_base[3] = BASE_W'($urandom_range(1, 1023));
		phase_idle[0] = 0;
		phase_idle[1] = 47;
		phase_idle[2] = 0;
		phase_idle[3] = 12;
		for (int p = 0; p < 4; p++) begin
			set_step_base(phase_base[p]);
			for (int i = 0; i < 400; i++) begin
				send_key(pick_key(35));
				pause(phase_idle[p]);
			end
		end

		// With a step of one every slot is probed, so fresh keys fill the table.
		set_step_base(10'd1);
		full_mark = n_full;
		for (int i = 0; i < 1200 && n_full == full_mark; i++) begin
			send_key(pick_key(100));
			pause(0);
		end
		repeat (24) begin
			send_key(pick_key(100));
			pause(47);
		end
		repeat (24) begin
			send_key(pick_key(0));
			pause(12);
		end
		set_step_base(BASE_W'($urandom_range(2, 1022)));
		repeat (16) begin
			send_key(pick_key(50));
			pause(47);
		end

		start <= 1'b0;
		for (int w = 0; w < 5000 && outstanding != 0; w++) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);

		$display("Covered %0d new inserts, %0d keys already present, %0d rejected as full.",
			n_inserted, n_present, n_full);
		$display("Step base was written %0d times, zero, one, two and the maximum among them.",
			n_settings);
		if (outstanding != 0) begin
			$error("%0d expected results never arrived", outstanding);
		end
		if (errors == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: double_hash_table_insert_unit.f
hdl/dht_pkg.sv
hdl/dht_ram.sv
hdl/dht_mod.sv
hdl/double_hash_table_insert_unit.sv
hdl/dht_checker.sv
bench/dht_insert_checker.sv
bench/double_hash_table_insert_unit_tb.sv
